// ===== sv/kdre_pkg.sv =====
package kdre_pkg;

  // configuration port geometry
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  // register indexes, one 32-bit word each
  localparam logic [2:0] RegLongPress   = 3'd0;
  localparam logic [2:0] RegRepeatStart = 3'd1;
  localparam logic [2:0] RegRepeatStep  = 3'd2;
  localparam logic [2:0] RegPause       = 3'd3;
  localparam logic [2:0] RegDebounce    = 3'd4;

  // register reset values
  localparam logic [7:0] LongPressRst   = 8'd32;
  localparam logic [7:0] RepeatStartRst = 8'd40;
  localparam logic [7:0] RepeatStepRst  = 8'd48;
  localparam logic [7:0] PauseRst       = 8'd64;
  localparam logic [3:0] DebounceRst    = 4'd4;

  // item commands
  localparam logic [1:0] ModeSample = 2'd0;
  localparam logic [1:0] ModePause  = 2'd1;
  localparam logic [1:0] ModeKill   = 2'd2;

  // event kinds
  localparam logic [1:0] EvFirst  = 2'd0;
  localparam logic [1:0] EvLong   = 2'd1;
  localparam logic [1:0] EvRepeat = 2'd2;
  localparam logic [1:0] EvBreak  = 2'd3;

  // key phases: repeat levels are the level value itself
  localparam logic [6:0] PhOff    = 7'd0;
  localparam logic [6:0] PhRep1   = 7'd1;
  localparam logic [6:0] PhRep2   = 7'd2;
  localparam logic [6:0] PhRep4   = 7'd4;
  localparam logic [6:0] PhRep8   = 7'd8;
  localparam logic [6:0] PhRep16  = 7'd16;
  localparam logic [6:0] PhDelay  = 7'd95;
  localparam logic [6:0] PhStart  = 7'd97;
  localparam logic [6:0] PhPause  = 7'd98;
  localparam logic [6:0] PhKilled = 7'd99;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] key_index;
    logic       pressed;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [2:0] event_key;
  } out_item_t;

  typedef struct packed {
    logic [7:0] history;
    logic [7:0] tick;
    logic [6:0] phase;
  } key_state_t;

  typedef struct packed {
    logic [7:0] long_press_ticks;
    logic [7:0] repeat_start_ticks;
    logic [7:0] repeat_step_ticks;
    logic [7:0] pause_ticks;
    logic [3:0] debounce_bits;
  } cfg_t;

  // history pattern that confirms a press, count clamped to 1..8
  function automatic logic [7:0] press_pattern(logic [3:0] db);
    logic [3:0] n;
    n = (db == 4'd0) ? 4'd1 : ((db > 4'd8) ? 4'd8 : db);
    return 8'((9'd1 << n) - 9'd1);
  endfunction

endpackage

// ===== sv/kdre_cfg.sv =====
module kdre_cfg
  import kdre_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ApbAddrW-1:2];

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegLongPress:   cfg_d.long_press_ticks   = pwdata[7:0];
        RegRepeatStart: cfg_d.repeat_start_ticks = pwdata[7:0];
        RegRepeatStep:  cfg_d.repeat_step_ticks  = pwdata[7:0];
        RegPause:       cfg_d.pause_ticks        = pwdata[7:0];
        RegDebounce:    cfg_d.debounce_bits      = pwdata[3:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks   <= LongPressRst;
      cfg_q.repeat_start_ticks <= RepeatStartRst;
      cfg_q.repeat_step_ticks  <= RepeatStepRst;
      cfg_q.pause_ticks        <= PauseRst;
      cfg_q.debounce_bits      <= DebounceRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      RegLongPress:   prdata = ApbDataW'(cfg_q.long_press_ticks);
      RegRepeatStart: prdata = ApbDataW'(cfg_q.repeat_start_ticks);
      RegRepeatStep:  prdata = ApbDataW'(cfg_q.repeat_step_ticks);
      RegPause:       prdata = ApbDataW'(cfg_q.pause_ticks);
      RegDebounce:    prdata = ApbDataW'(cfg_q.debounce_bits);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/kdre_mem.sv =====
module kdre_mem
  import kdre_pkg::*;
#(
  parameter int unsigned KEY_COUNT = 8,
  parameter int unsigned AddrW     = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output key_state_t       rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  key_state_t       wr_data_i
);

  key_state_t           mem_q [KEY_COUNT];
  logic [KEY_COUNT-1:0] vld_q;
  key_state_t           rd_data_q;
  logic                 rd_vld_q;

  // storage, write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // one valid bit per key, an unwritten key reads as all zeros
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // registered read port, old data on a same-edge write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (rd_en_i) begin
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== sv/kdre_next.sv =====
module kdre_next
  import kdre_pkg::*;
(
  input  cfg_t       cfg_i,
  input  in_item_t   item_i,
  input  logic       key_ok_i,
  input  key_state_t cur_i,
  output key_state_t nxt_o,
  output logic       wr_en_o,
  output logic       emit_o,
  output out_item_t  res_o
);

  logic [7:0] hist_n;
  logic [7:0] tick_n;
  logic [6:0] lvl_n;
  logic [7:0] lvl_mask;

  assign hist_n = {cur_i.history[6:0], item_i.pressed};
  assign tick_n = cur_i.tick + 8'd1;

  // repeat level after a possible halving, and the tick mask it sets
  always_comb begin
    lvl_n  = cur_i.phase;
    if (tick_n >= cfg_i.repeat_step_ticks) begin
      lvl_n = cur_i.phase >> 1;
    end
    lvl_mask = 8'(lvl_n - 7'd1);
  end

  // per-key update for one item
  always_comb begin
    nxt_o              = cur_i;
    wr_en_o            = 1'b0;
    emit_o             = 1'b0;
    res_o.event_kind   = EvFirst;
    res_o.event_key    = item_i.key_index;
    if (key_ok_i) begin
      unique case (item_i.mode)
        ModeSample: begin
          wr_en_o       = 1'b1;
          nxt_o.history = hist_n;
          nxt_o.tick    = tick_n;
          if (cur_i.phase != PhOff && hist_n == 8'd0) begin
            // release
            nxt_o.phase = PhOff;
            nxt_o.tick  = 8'd0;
            if (cur_i.phase != PhKilled) begin
              emit_o           = 1'b1;
              res_o.event_kind = EvBreak;
            end
          end else begin
            unique case (cur_i.phase)
              PhOff: begin
                if (hist_n == press_pattern(cfg_i.debounce_bits)) begin
                  nxt_o.phase = PhStart;
                  nxt_o.tick  = 8'd0;
                end
              end
              PhStart: begin
                nxt_o.phase      = PhDelay;
                nxt_o.tick       = 8'd0;
                emit_o           = 1'b1;
                res_o.event_kind = EvFirst;
              end
              PhDelay: begin
                if (tick_n == cfg_i.long_press_ticks) begin
                  emit_o           = 1'b1;
                  res_o.event_kind = EvLong;
                end
                if (tick_n == cfg_i.repeat_start_ticks) begin
                  nxt_o.phase = PhRep16;
                  nxt_o.tick  = 8'd0;
                end
              end
              PhRep16, PhRep8, PhRep4, PhRep2: begin
                if (lvl_n != cur_i.phase) begin
                  nxt_o.phase = lvl_n;
                  nxt_o.tick  = 8'd0;
                  // counter cleared, so the mask test passes
                  emit_o           = 1'b1;
                  res_o.event_kind = EvRepeat;
                end else if ((tick_n & lvl_mask) == 8'd0) begin
                  emit_o           = 1'b1;
                  res_o.event_kind = EvRepeat;
                end
              end
              PhRep1: begin
                emit_o           = 1'b1;
                res_o.event_kind = EvRepeat;
              end
              PhPause: begin
                if (tick_n >= cfg_i.pause_ticks) begin
                  nxt_o.phase = PhRep8;
                  nxt_o.tick  = 8'd0;
                end
              end
              default: begin
                nxt_o.phase = cur_i.phase;
              end
            endcase
          end
        end
        ModePause: begin
          wr_en_o     = 1'b1;
          nxt_o.phase = PhPause;
          nxt_o.tick  = 8'd0;
        end
        ModeKill: begin
          wr_en_o     = 1'b1;
          nxt_o.phase = PhKilled;
        end
        default: begin
          wr_en_o = 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== sv/key_debounce_repeat_events_unit.sv =====
// channel   | signals                               | payload
// ----------+---------------------------------------+--------------------------
// cfg       | psel penable pwrite paddr pwdata ...  | 32-bit registers at 4*i
// in        | in_valid_i / in_ready_o               | in_data_i  (in_item_t)
// out       | out_valid_o / out_ready_i             | out_data_o (out_item_t)
//
// one item per cycle sustained unless a held result stalls the update stage; an event
// passes the key state read from the state memory, then update and result register
// a key touched by consecutive items is forwarded from the last write-back
// reset clears the per-key valid bits at once, no clearing pass, no idle time
// a held result stalls the update stage only when that stage has an event
module key_debounce_repeat_events_unit
  import kdre_pkg::*;
#(
  parameter int unsigned KEY_COUNT = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o
);

  localparam int unsigned AddrW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  cfg_t             cfg;
  logic             in_xfer;
  logic [AddrW-1:0] in_addr;

  // update stage
  logic             s1_vld_q;
  in_item_t         s1_item_q;
  logic [AddrW-1:0] s1_addr;
  logic             s1_key_ok;
  logic             s1_fire;
  key_state_t       mem_rd;
  key_state_t       cur_state;
  key_state_t       nxt_state;
  logic             upd_we;
  logic             upd_emit;
  out_item_t        upd_res;
  logic             mem_we;

  // last write-back, for forwarding
  logic             wb_vld_q;
  logic [AddrW-1:0] wb_addr_q;
  key_state_t       wb_state_q;

  // result register
  logic             out_vld_q;
  out_item_t        out_data_q;

  kdre_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .cfg_o (cfg)
  );

  assign in_addr    = AddrW'(in_data_i.key_index);
  assign in_ready_o = !s1_vld_q || s1_fire;
  assign in_xfer    = in_valid_i && in_ready_o;

  kdre_mem #(
    .KEY_COUNT (KEY_COUNT),
    .AddrW     (AddrW)
  ) u_mem (
    .clk_i,
    .rst_ni,
    .rd_en_i   (in_xfer),
    .rd_addr_i (in_addr),
    .rd_data_o (mem_rd),
    .wr_en_i   (mem_we),
    .wr_addr_i (s1_addr),
    .wr_data_i (nxt_state)
  );

  // update stage holds the item whose key state is being read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_vld_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= in_data_i;
    end
  end

  assign s1_addr   = AddrW'(s1_item_q.key_index);
  assign s1_key_ok = 32'(s1_item_q.key_index) < KEY_COUNT;

  // forward the write that landed on the same edge as this item's read
  assign cur_state = (wb_vld_q && wb_addr_q == s1_addr) ? wb_state_q : mem_rd;

  kdre_next u_next (
    .cfg_i    (cfg),
    .item_i   (s1_item_q),
    .key_ok_i (s1_key_ok),
    .cur_i    (cur_state),
    .nxt_o    (nxt_state),
    .wr_en_o  (upd_we),
    .emit_o   (upd_emit),
    .res_o    (upd_res)
  );

  assign s1_fire = s1_vld_q && (!upd_emit || !out_vld_q || out_ready_i);
  assign mem_we  = s1_fire && upd_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_vld_q <= 1'b0;
    end else if (mem_we) begin
      wb_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      wb_addr_q  <= s1_addr;
      wb_state_q <= nxt_state;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_fire && upd_emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && upd_emit) begin
      out_data_q <= upd_res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

  // an accepted item always reaches the update stage
  a_xfer_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> s1_vld_q)
    else $error("accepted item lost before update stage");

  // a stalled update stage keeps its item
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !s1_fire |=> s1_vld_q && $stable(s1_item_q))
    else $error("update stage changed while stalled");

  // state is written back only by a finished update
  a_write_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> s1_vld_q && s1_key_ok)
    else $error("state write without a valid in-range item");

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |-> !(s1_fire && upd_emit))
    else $error("pending result overwritten");

  // events only name keys that exist
  a_event_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> 32'(out_data_q.event_key) < KEY_COUNT)
    else $error("event for a key outside the key count");

endmodule
